@@ hdl/ptbr_pkg.sv @@
// Package for the planar tile border renderer: request and result beats,
// function codes, store geometry and color expansion. No dependencies.
`timescale 1ns / 1ps

package ptbr_pkg;

  typedef enum logic [1:0] {
    FUNC_TILE   = 2'd0,
    FUNC_MAP    = 2'd1,
    FUNC_PAL    = 2'd2,
    FUNC_RENDER = 2'd3
  } func_e;

  typedef struct packed {
    func_e       func;
    logic [12:0] addr;
    logic [14:0] wdata;
    logic [7:0]  pix_y;
    logic [7:0]  pix_x;
  } req_t;

  typedef struct packed {
    logic [23:0] rgb;
    logic        opaque;
  } res_t;

  // map store size in bytes, anywhere from 1792 to 4096
  localparam int MAP_BYTES = 2048;
  localparam int MAP_AW    = $clog2(MAP_BYTES);

  // pattern store: one word per tile row, one 8-bit lane per bit plane
  localparam int PAT_LANES = 4;
  localparam int PAT_WORDS = 2048;
  localparam int PAT_AW    = $clog2(PAT_WORDS);

  localparam int COLORS   = 128;
  localparam int COLOR_AW = $clog2(COLORS);

  // fold a map byte index (below twice MAP_BYTES) back into the store
  function automatic logic [12:0] map_wrap(logic [12:0] v);
    logic [12:0] m;
    m = 13'(MAP_BYTES);
    return (v >= m) ? v - m : v;
  endfunction

  function automatic logic [7:0] expand5(logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  // BGR555 (red in the low bits) to RGB888 (red in the top byte)
  function automatic logic [23:0] bgr_to_rgb(logic [14:0] c);
    return {expand5(c[4:0]), expand5(c[9:5]), expand5(c[14:10])};
  endfunction

endpackage

@@ hdl/ptbr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Used for all stores of the planar tile border renderer; no dependencies.
`timescale 1ns / 1ps

module ptbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/planar_tile_border_renderer.sv @@
// Top level of the planar tile border renderer: map, pattern and color
// stores in ptbr_ram instances, three-stage lookup pipeline. Uses ptbr_pkg.
`timescale 1ns / 1ps

// A beat is taken on every clock where start_i is high; busy_o stays low, so
// tile, map, palette and render beats may follow one another every cycle.
// A render beat gives its result on res_o with res_valid_o high for exactly
// one cycle, after the s1, s2 and s3 registers; write beats give no result.
// The stages follow the chain of dependent reads: map entry, then the four
// plane bytes of the tile row, then the palette color. Each store is read and
// written in its own pipeline stage, so writes and renders keep their order
// per store without stalls. The receiver cannot hold off results. Stores are
// not cleared and must be loaded before a render reads them.

module planar_tile_border_renderer
  import ptbr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic res_valid_o,
  output res_t res_o
);

  typedef struct packed {
    func_e       func;
    logic [12:0] addr;
    logic [14:0] wdata;
    logic [2:0]  row;
    logic [2:0]  col;
  } s1_t;

  typedef struct packed {
    func_e       func;
    logic [12:0] addr;
    logic [14:0] wdata;
    logic [2:0]  pal;
    logic [2:0]  col;
  } s2_t;

  logic accept;

  // stage 0: map access
  logic [12:0]       map_lo_idx, map_hi_idx;
  logic              map_we;
  logic [7:0]        map_lo_rd, map_hi_rd;

  // stage 1: pattern access
  logic              s1_vld_q;
  s1_t               s1_q;
  logic [15:0]       entry;
  logic [2:0]        row_f, col_f;
  logic [PAT_AW-1:0] pat_raddr, pat_waddr;
  logic [1:0]        pat_lane;
  logic [PAT_LANES-1:0] pat_we;
  logic [7:0]        pat_rd [PAT_LANES];

  // stage 2: color access
  logic              s2_vld_q;
  s2_t               s2_q;
  logic [2:0]        bit_sel;
  logic [3:0]        cidx;
  logic              col_we;
  logic [14:0]       col_rd;

  // stage 3: result
  logic              s3_vld_q;
  logic              s3_opaque_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // ---------------- stage 0 ----------------
  assign map_lo_idx = map_wrap({2'b00, req_i.pix_y[7:3], req_i.pix_x[7:3], 1'b0});
  assign map_hi_idx = map_wrap({2'b00, req_i.pix_y[7:3], req_i.pix_x[7:3], 1'b1});
  assign map_we     = accept && (req_i.func == FUNC_MAP) && (req_i.addr < 13'(MAP_BYTES));

  // two copies so both entry bytes come out in one read
  ptbr_ram #(.WIDTH(8), .DEPTH(MAP_BYTES)) u_map_lo (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (req_i.addr[MAP_AW-1:0]),
    .wdata_i (req_i.wdata[7:0]),
    .raddr_i (map_lo_idx[MAP_AW-1:0]),
    .rdata_o (map_lo_rd)
  );

  ptbr_ram #(.WIDTH(8), .DEPTH(MAP_BYTES)) u_map_hi (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (req_i.addr[MAP_AW-1:0]),
    .wdata_i (req_i.wdata[7:0]),
    .raddr_i (map_hi_idx[MAP_AW-1:0]),
    .rdata_o (map_hi_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.func  <= req_i.func;
      s1_q.addr  <= req_i.addr;
      s1_q.wdata <= req_i.wdata;
      s1_q.row   <= req_i.pix_y[2:0];
      s1_q.col   <= req_i.pix_x[2:0];
    end
  end

  // ---------------- stage 1 ----------------
  assign entry = {map_hi_rd, map_lo_rd};
  assign row_f = entry[15] ? ~s1_q.row : s1_q.row;
  assign col_f = entry[14] ? ~s1_q.col : s1_q.col;

  assign pat_raddr = {entry[7:0], row_f};
  // byte address: tile, upper plane pair, row, plane within pair
  assign pat_waddr = {s1_q.addr[12:5], s1_q.addr[3:1]};
  assign pat_lane  = {s1_q.addr[4], s1_q.addr[0]};

  for (genvar l = 0; l < PAT_LANES; l++) begin : g_plane
    assign pat_we[l] = s1_vld_q && (s1_q.func == FUNC_TILE) && (pat_lane == 2'(l));

    ptbr_ram #(.WIDTH(8), .DEPTH(PAT_WORDS)) u_plane (
      .clk_i   (clk_i),
      .we_i    (pat_we[l]),
      .waddr_i (pat_waddr),
      .wdata_i (s1_q.wdata[7:0]),
      .raddr_i (pat_raddr),
      .rdata_o (pat_rd[l])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      s2_q.func  <= s1_q.func;
      s2_q.addr  <= s1_q.addr;
      s2_q.wdata <= s1_q.wdata;
      s2_q.pal   <= entry[12:10];
      s2_q.col   <= col_f;
    end
  end

  // ---------------- stage 2 ----------------
  // bit 7 is the leftmost pixel
  assign bit_sel = ~s2_q.col;
  assign cidx    = {pat_rd[3][bit_sel], pat_rd[2][bit_sel],
                    pat_rd[1][bit_sel], pat_rd[0][bit_sel]};
  assign col_we  = s2_vld_q && (s2_q.func == FUNC_PAL) && (s2_q.addr < 13'(COLORS));

  ptbr_ram #(.WIDTH(15), .DEPTH(COLORS)) u_color (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (s2_q.addr[COLOR_AW-1:0]),
    .wdata_i (s2_q.wdata),
    .raddr_i ({s2_q.pal, cidx}),
    .rdata_o (col_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q && (s2_q.func == FUNC_RENDER);
    end
  end

  always_ff @(posedge clk_i) begin
    s3_opaque_q <= (cidx != 4'd0);
  end

  // ---------------- stage 3 ----------------
  assign res_valid_o = s3_vld_q;
  assign res_o.opaque = s3_opaque_q;
  assign res_o.rgb    = s3_opaque_q ? bgr_to_rgb(col_rd) : 24'd0;

`ifndef SYNTHESIS
  a_res_from_render: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start_i && (req_i.func == FUNC_RENDER), 3))
    else $error("result beat without a render beat three cycles earlier");

  a_plane_we_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(pat_we))
    else $error("tile byte written into more than one plane");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && (s2_q.func != FUNC_RENDER)) |=> !res_valid_o)
    else $error("write beat produced a result");
`endif

endmodule

@@ tb/tb_planar_tile_border_renderer.sv @@
// Testbench for planar_tile_border_renderer: loads the tile, map and palette
// stores, renders border pixels and checks each pixel against a local predictor.
// Depends on ptbr_pkg and the renderer RTL.
`timescale 1ns / 1ps

module tb_planar_tile_border_renderer
  import ptbr_pkg::*;
;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  req_t req_i;
  logic busy_o;
  logic res_valid_o;
  res_t res_o;

  planar_tile_border_renderer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // local copy of the stores, plus which entries have been loaded
  logic [7:0]  tile_bytes[8192];
  logic [7:0]  map_bytes[MAP_BYTES];
  logic [14:0] palette[COLORS];
  bit          tile_loaded[8192];
  bit          map_loaded[MAP_BYTES];
  bit          color_loaded[COLORS];

  res_t expected_pixels[$];
  res_t due_pixel;
  int   pixel_errors = 0;
  int   gap_pct      = 17;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int map_index(logic [7:0] py, logic [7:0] px);
    return ((int'(py) >> 3) * 32 + (int'(px) >> 3)) * 2;
  endfunction

  function automatic logic [15:0] map_entry(logic [7:0] py, logic [7:0] px);
    int mi;
    mi = map_index(py, px);
    return {map_bytes[(mi + 1) % MAP_BYTES], map_bytes[mi % MAP_BYTES]};
  endfunction

  function automatic int tile_row_base(logic [15:0] entry, logic [7:0] py);
    logic [2:0] row;
    row = py[2:0];
    if (entry[15]) row = ~row;
    return int'(entry[7:0]) * 32 + int'(row) * 2;
  endfunction

  function automatic logic [3:0] pixel_cidx(logic [7:0] py, logic [7:0] px);
    logic [15:0] entry;
    logic [2:0]  col;
    int          base;
    int          sh;
    entry = map_entry(py, px);
    base  = tile_row_base(entry, py);
    col   = px[2:0];
    if (entry[14]) col = ~col;
    sh = 7 - int'(col);
    return {tile_bytes[base + 17][sh], tile_bytes[base + 16][sh],
            tile_bytes[base + 1][sh], tile_bytes[base][sh]};
  endfunction

  function automatic res_t predict_pixel(logic [7:0] py, logic [7:0] px);
    logic [15:0] entry;
    logic [3:0]  idx;
    logic [14:0] c;
    res_t        px_out;
    entry = map_entry(py, px);
    idx   = pixel_cidx(py, px);
    px_out = '0;
    if (idx != 4'd0) begin
      c = palette[{entry[12:10], idx}];
      px_out.rgb    = {c[4:0], c[4:2], c[9:5], c[9:7], c[14:10], c[14:12]};
      px_out.opaque = 1'b1;
    end
    return px_out;
  endfunction

  // update the local stores for an accepted beat, or queue its pixel
  function automatic void apply_beat(req_t r);
    case (r.func)
      FUNC_TILE: begin
        tile_bytes[r.addr]  = r.wdata[7:0];
        tile_loaded[r.addr] = 1'b1;
      end
      FUNC_MAP: begin
        if (r.addr < 13'(MAP_BYTES)) begin
          map_bytes[r.addr]  = r.wdata[7:0];
          map_loaded[r.addr] = 1'b1;
        end
      end
      FUNC_PAL: begin
        if (r.addr < 13'(COLORS)) begin
          palette[r.addr]      = r.wdata;
          color_loaded[r.addr] = 1'b1;
        end
      end
      FUNC_RENDER: expected_pixels.push_back(predict_pixel(r.pix_y, r.pix_x));
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- driving

  function automatic req_t noise_req(func_e f);
    req_t r;
    r.func  = f;
    r.addr  = 13'($urandom);
    r.wdata = 15'($urandom);
    r.pix_y = 8'($urandom);
    r.pix_x = 8'($urandom);
    return r;
  endfunction

  task automatic send_beat(input req_t r);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    req_i   <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    apply_beat(r);
  endtask

  task automatic write_store(input func_e f, input logic [12:0] a, input logic [14:0] d);
    req_t r;
    r       = noise_req(f);
    r.addr  = a;
    r.wdata = d;
    send_beat(r);
  endtask

  task automatic render_pixel(input logic [7:0] py, input logic [7:0] px);
    req_t r;
    r       = noise_req(FUNC_RENDER);
    r.pix_y = py;
    r.pix_x = px;
    send_beat(r);
  endtask

  // fill whatever the pixel reads that is still unloaded, then render it
  task automatic load_and_render(input logic [7:0] py, input logic [7:0] px);
    int          mi;
    int          base;
    int          offs[4];
    logic [15:0] entry;
    logic [3:0]  idx;
    logic [6:0]  ci;
    offs = '{0, 1, 16, 17};
    mi   = map_index(py, px);
    for (int k = 0; k < 2; k++) begin
      if (!map_loaded[(mi + k) % MAP_BYTES])
        write_store(FUNC_MAP, 13'((mi + k) % MAP_BYTES), 15'($urandom));
    end
    entry = map_entry(py, px);
    base  = tile_row_base(entry, py);
    foreach (offs[k]) begin
      if (!tile_loaded[base + offs[k]])
        write_store(FUNC_TILE, 13'(base + offs[k]), 15'($urandom));
    end
    idx = pixel_cidx(py, px);
    ci  = {entry[12:10], idx};
    if (idx != 4'd0 && !color_loaded[ci])
      write_store(FUNC_PAL, 13'(ci), 15'($urandom));
    render_pixel(py, px);
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (expected_pixels.size() == 0) begin
        pixel_errors++;
        $display("%0t: unexpected pixel rgb=%06h opaque=%b", $time, res_o.rgb, res_o.opaque);
      end else begin
        due_pixel = expected_pixels.pop_front();
        if (res_o.rgb !== due_pixel.rgb) begin
          pixel_errors++;
          $display("%0t: rgb expected %06h actual %06h", $time, due_pixel.rgb, res_o.rgb);
        end
        if (res_o.opaque !== due_pixel.opaque) begin
          pixel_errors++;
          $display("%0t: opaque expected %b actual %b", $time, due_pixel.opaque,
                   res_o.opaque);
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // tile 255, palette 7, both flips, ignored map bits set, full-scale colors
  task automatic test_store_extremes();
    write_store(FUNC_MAP, 13'd0, 15'h7FFF);
    write_store(FUNC_MAP, 13'd1, 15'h7FFF);
    write_store(FUNC_TILE, 13'd8174, 15'h00FF);
    write_store(FUNC_TILE, 13'd8175, 15'h00FF);
    write_store(FUNC_TILE, 13'd8190, 15'h00FF);
    write_store(FUNC_TILE, 13'd8191, 15'h7FFE);
    write_store(FUNC_PAL, 13'd127, 15'h7FFF);
    write_store(FUNC_PAL, 13'd119, 15'h0000);
    render_pixel(8'd0, 8'd1);
    render_pixel(8'd0, 8'd0);
  endtask

  // color index zero, at the bottom-right map entry
  task automatic test_transparent_pixels();
    write_store(FUNC_MAP, 13'd2046, 15'h7F00);
    write_store(FUNC_MAP, 13'd2047, 15'h7F00);
    write_store(FUNC_TILE, 13'd0, 15'h7F00);
    write_store(FUNC_TILE, 13'd1, 15'h7F00);
    write_store(FUNC_TILE, 13'd16, 15'h7F00);
    write_store(FUNC_TILE, 13'd17, 15'h7F00);
    render_pixel(8'd248, 8'd248);
    render_pixel(8'd248, 8'd255);
  endtask

  // out-of-range map and palette writes must not alias onto live entries
  task automatic test_ignored_writes();
    write_store(FUNC_MAP, 13'(MAP_BYTES), 15'h0000);
    write_store(FUNC_MAP, 13'h1FFF, 15'h0000);
    write_store(FUNC_PAL, 13'(COLORS), 15'h0000);
    write_store(FUNC_PAL, 13'(COLORS + 127), 15'h0000);
    render_pixel(8'd0, 8'd1);
  endtask

  task automatic test_mixed_traffic(input int n);
    int   sel;
    req_t r;
    repeat (n) begin
      sel = $urandom_range(99);
      if (sel < 35) begin
        load_and_render(8'($urandom), 8'($urandom));
      end else if (sel < 55) begin
        // small window, so overwrites hit pixels that get rendered again
        load_and_render(8'($urandom_range(31)), 8'($urandom_range(31)));
      end else begin
        r = noise_req(func_e'($urandom_range(2)));
        if (r.func == FUNC_MAP && $urandom_range(9) != 0)
          r.addr = 13'($urandom_range(MAP_BYTES - 1));
        if (r.func == FUNC_PAL && $urandom_range(9) != 0)
          r.addr = 13'($urandom_range(COLORS - 1));
        if (r.func == FUNC_TILE && $urandom_range(1) == 0)
          r.addr = 13'($urandom_range(1023));
        send_beat(r);
      end
    end
  endtask

  task automatic test_back_to_back(input int n);
    gap_pct = 0;
    test_mixed_traffic(n);
    gap_pct = 17;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    int guard;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    req_i   = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_store_extremes();
    test_transparent_pixels();
    test_ignored_writes();
    test_mixed_traffic(160);
    test_back_to_back(100);
    test_mixed_traffic(80);

    @(negedge clk_i);
    start_i <= 1'b0;
    guard = 0;
    while (expected_pixels.size() != 0 && guard < 200) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
    if (expected_pixels.size() != 0)
      $display("%0t: %0d pixels never returned", $time, expected_pixels.size());
    if (pixel_errors == 0 && expected_pixels.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
